// ===== rtl/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg - shared types and constants for the RMC position parser
// Byte classes, queue beat layout and header characters.
// ----------------------------------------------------------------------------
`default_nettype none

package rmc_pkg;

	localparam int LAT_CHARS   = 7;
	localparam int LON_CHARS   = 8;
	localparam int LAT_W       = 8 * LAT_CHARS;
	localparam int LON_W       = 8 * LON_CHARS;
	localparam int HDR_LEN     = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] MAX_LEN_RST = 8'd100;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_ACTIVE   = 8'h41;

	// field positions of interest
	localparam logic [2:0] FLD_STATUS = 3'd2;
	localparam logic [2:0] FLD_LAT    = 3'd3;
	localparam logic [2:0] FLD_NS     = 3'd4;
	localparam logic [2:0] FLD_LON    = 3'd5;
	localparam logic [2:0] FLD_EW     = 3'd6;
	localparam logic [2:0] FLD_MAX    = 3'd7;
	localparam logic [2:0] FLD_MIN_OK = 3'd5;

	typedef enum logic [2:0] {
		K_DOLLAR,
		K_LF,
		K_CR,
		K_COMMA,
		K_OTHER
	} rmc_kind_t;

	typedef struct packed {
		rmc_kind_t  kind;
		logic [7:0] data;
	} rmc_beat_t;

	typedef struct packed {
		logic      valid;
		rmc_beat_t beat;
	} rmc_head_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h24; // $
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h50; // P
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4D; // M
			3'd5:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rmc_if.sv =====
// ----------------------------------------------------------------------------
// rmc_if - valid/ready channels of the RMC position parser
// Byte input channel and fix result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rmc_fix_if;
	logic               valid;
	logic               ready;
	logic               fix_ok;
	logic [55:0]        lat_text;
	logic [7:0]         ns_char;
	logic signed [63:0] lon_text;
	logic [7:0]         ew_char;

	modport source (output valid, output fix_ok, output lat_text, output ns_char,
		output lon_text, output ew_char, input ready);
	modport sink   (input valid, input fix_ok, input lat_text, input ns_char,
		input lon_text, input ew_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/rmc_front.sv =====
// ----------------------------------------------------------------------------
// rmc_front - byte intake and classification
// Tags each accepted byte with its class and holds it in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rmc_byte_if.sink           byte_in,
	input  wire logic          pop,
	output rmc_pkg::rmc_head_t head
);
	import rmc_pkg::*;

	rmc_beat_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	rmc_beat_t           beat_in;
	logic                push;
	logic                do_pop;

	always_comb begin
		beat_in.data = byte_in.rx_byte;
		unique case (byte_in.rx_byte)
			CH_DOLLAR: beat_in.kind = K_DOLLAR;
			CH_LF:     beat_in.kind = K_LF;
			CH_CR:     beat_in.kind = K_CR;
			CH_COMMA:  beat_in.kind = K_COMMA;
			default:   beat_in.kind = K_OTHER;
		endcase
	end

	assign byte_in.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push          = byte_in.valid && byte_in.ready;
	assign do_pop        = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.beat  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= beat_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rmc_back.sv =====
// ----------------------------------------------------------------------------
// rmc_back - sentence tracking and result register
// Walks the queued bytes through the sentence state and emits one fix per end.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata,
	input  wire rmc_pkg::rmc_head_t head,
	output logic               pop,
	rmc_fix_if.source          fix_out
);
	import rmc_pkg::*;

	logic [7:0]       max_len_q;
	logic             in_sent_q,  in_sent_d;
	logic [7:0]       cnt_q,      cnt_d;
	logic             hdr_ok_q,   hdr_ok_d;
	logic [2:0]       fld_q,      fld_d;
	logic [3:0]       cif_q,      cif_d;
	logic             stat_q,     stat_d;
	logic [LAT_W-1:0] lat_q,      lat_d;
	logic [7:0]       ns_q,       ns_d;
	logic [LON_W-1:0] lon_q,      lon_d;
	logic [7:0]       ew_q,       ew_d;

	logic             out_valid_q;
	logic             fix_ok_q;
	logic [LAT_W-1:0] lat_out_q;
	logic [7:0]       ns_out_q;
	logic [LON_W-1:0] lon_out_q;
	logic [7:0]       ew_out_q;

	logic [7:0]       limit;
	logic             emit;
	logic             fix_ok;
	logic             out_free;
	logic [7:0]       c;
	logic [2:0]       lat_slot;
	logic [2:0]       lon_slot;

	assign limit    = (max_len_q == 8'd0) ? 8'd0 : max_len_q - 8'd1;
	assign c        = head.beat.data;
	assign lat_slot = 3'(LAT_CHARS - 1) - cif_q[2:0];
	assign lon_slot = 3'(LON_CHARS - 1) - cif_q[2:0];
	assign fix_ok   = hdr_ok_q && (cnt_q >= 8'(HDR_LEN)) && stat_q && (fld_q >= FLD_MIN_OK);

	always_comb begin
		in_sent_d = in_sent_q;
		cnt_d     = cnt_q;
		hdr_ok_d  = hdr_ok_q;
		fld_d     = fld_q;
		cif_d     = cif_q;
		stat_d    = stat_q;
		lat_d     = lat_q;
		ns_d      = ns_q;
		lon_d     = lon_q;
		ew_d      = ew_q;
		emit      = 1'b0;

		if (!in_sent_q) begin
			if (head.beat.kind == K_DOLLAR) begin
				// '$' is the first header char: it matches and opens field 0
				in_sent_d = 1'b1;
				cnt_d     = 8'd1;
				hdr_ok_d  = 1'b1;
				fld_d     = '0;
				cif_d     = 4'd1;
				stat_d    = 1'b0;
				lat_d     = '0;
				ns_d      = '0;
				lon_d     = '0;
				ew_d      = '0;
			end
		end else if (head.beat.kind == K_LF || cnt_q >= limit) begin
			emit      = 1'b1;
			in_sent_d = 1'b0;
		end else if (head.beat.kind != K_CR) begin
			if (cnt_q < 8'(HDR_LEN) && c != hdr_char(cnt_q[2:0])) begin
				hdr_ok_d = 1'b0;
			end
			if (head.beat.kind == K_COMMA) begin
				if (fld_q != FLD_MAX) begin
					fld_d = fld_q + 3'd1;
				end
				cif_d = '0;
			end else begin
				unique case (fld_q)
					FLD_STATUS: if (cif_q == '0) stat_d = (c == CH_ACTIVE);
					FLD_LAT: if (cif_q < 4'(LAT_CHARS)) begin
						lat_d[lat_slot*8 +: 8] = lat_q[lat_slot*8 +: 8] | c;
					end
					FLD_NS:  if (cif_q == '0) ns_d = c;
					FLD_LON: if (cif_q < 4'(LON_CHARS)) begin
						lon_d[lon_slot*8 +: 8] = lon_q[lon_slot*8 +: 8] | c;
					end
					FLD_EW:  if (cif_q == '0) ew_d = c;
					default: ;
				endcase
				if (cif_q != 4'd15) begin
					cif_d = cif_q + 4'd1;
				end
			end
			if (cnt_q != 8'd255) begin
				cnt_d = cnt_q + 8'd1;
			end
		end
	end

	assign out_free = !out_valid_q || fix_out.ready;
	assign pop      = head.valid && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= MAX_LEN_RST;
			in_sent_q   <= 1'b0;
			cnt_q       <= '0;
			hdr_ok_q    <= 1'b0;
			fld_q       <= '0;
			cif_q       <= '0;
			stat_q      <= 1'b0;
			lat_q       <= '0;
			ns_q        <= '0;
			lon_q       <= '0;
			ew_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (pop) begin
				in_sent_q <= in_sent_d;
				cnt_q     <= cnt_d;
				hdr_ok_q  <= hdr_ok_d;
				fld_q     <= fld_d;
				cif_q     <= cif_d;
				stat_q    <= stat_d;
				lat_q     <= lat_d;
				ns_q      <= ns_d;
				lon_q     <= lon_d;
				ew_q      <= ew_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (fix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; text is zeroed for a rejected sentence
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			fix_ok_q  <= fix_ok;
			lat_out_q <= fix_ok ? lat_q : '0;
			ns_out_q  <= fix_ok ? ns_q  : '0;
			lon_out_q <= fix_ok ? lon_q : '0;
			ew_out_q  <= fix_ok ? ew_q  : '0;
		end
	end

	assign fix_out.valid    = out_valid_q;
	assign fix_out.fix_ok   = fix_ok_q;
	assign fix_out.lat_text = lat_out_q;
	assign fix_out.ns_char  = ns_out_q;
	assign fix_out.lon_text = lon_out_q;
	assign fix_out.ew_char  = ew_out_q;

endmodule

`default_nettype wire

// ===== rtl/nmea_rmc_position_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser - GPRMC sentence position extractor
// Byte stream in, one position fix out per sentence end.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in  : one received character per beat (valid/ready).
//   fix_out  : one beat per sentence end: fix_ok plus latitude, N/S,
//              longitude and E/W text (text is zero when fix_ok is low).
//   cfg_we / cfg_wdata : write of max_length (reset 100); write only while
//              no sentence byte is in flight.
// Throughput: one byte per cycle unless a stalled fix_out holds the back,
//   with no gap between sentences. The front classifies bytes into a
//   2-beat queue; the back walks the sentence state byte by byte.
// Path: a sentence-ending byte is written into the queue, and its fix is
//   then captured in the output register that drives fix_out.
// Stall: a stalled fix_out holds the back only when the head byte would end
//   another sentence; other bytes keep flowing, and byte_in.ready drops
//   once the queue is full.
// Reset: arst_n clears the queue, the sentence state and the output valid;
//   max_length returns to 100. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_position_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	rmc_byte_if.sink        byte_in,
	rmc_fix_if.source       fix_out
);
	import rmc_pkg::*;

	rmc_head_t head;
	logic      pop;

	// front: intake, byte class, queue
	rmc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.pop     (pop),
		.head    (head)
	);

	// back: sentence state machine and result register
	rmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.fix_out   (fix_out)
	);

`ifndef SYNTHESIS
	// a rejected fix carries no text
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fix_out.valid && !fix_out.fix_ok) |->
		(fix_out.lat_text == '0 && fix_out.ns_char == '0 &&
		 fix_out.lon_text == '0 && fix_out.ew_char == '0))
		else $error("rejected fix carries text");

	// the queue only fills up behind a pending fix
	a_full_needs_fix: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_in.ready |-> fix_out.valid)
		else $error("byte input stalled with no fix pending");

	// a stalled byte input means the back was blocked in the previous cycle too
	a_full_from_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_in.ready |-> $past(fix_out.valid && !fix_out.ready))
		else $error("queue full without output stall");
`endif

endmodule

`default_nettype wire
